// ----- design/rdx_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdx_pkg: shared constants and helpers for integer_to_radix_digits
// Field widths, radix limits, divider step size and the digit symbol map.
// ----------------------------------------------------------------------------
package rdx_pkg;

	localparam int VALUE_IN_W  = 64;  // width of the value field on the input
	localparam int RADIX_W     = 6;
	localparam int CHAR_W      = 7;
	localparam int OUT_DATA_W  = 8;   // digit_char padded to a whole byte
	localparam int DIV_BITS    = 8;   // dividend bits consumed per divider cycle
	localparam int STORE_DEPTH = 64;
	localparam int STORE_AW    = 6;
	localparam int CNT_W       = 7;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

	localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'h30;  // '0'
	localparam logic [CHAR_W-1:0] CHAR_A      = 7'h41;  // 'A'
	localparam logic [CHAR_W-1:0] CHAR_TOP    = 7'h5A;  // 'Z'

	// Digit value to ASCII symbol of 0-9A-Z; anything past 35 reads as 'Z'.
	function automatic logic [CHAR_W-1:0] digit_to_char(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < 6'd10) begin
			c = CHAR_ZERO + CHAR_W'(d);
		end else if (d < RADIX_MAX) begin
			c = CHAR_A + CHAR_W'(d - 6'd10);
		end else begin
			c = CHAR_TOP;
		end
		return c;
	endfunction

endpackage

// ----- design/integer_to_radix_digits.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_radix_digits: unsigned integer to ASCII digits in radix 2..36
//
// Input stream s_*: one word per integer (value in tdata). Output stream m_*:
// one word per digit, most significant first, tlast on the final digit.
// cfg_we/cfg_wdata write the radix; 0 and 1 act as 2, 37..63 act as 36.
// Write it only while the block is idle. Reset sets the radix to ten and
// empties the input queue; no digits are pending after reset.
//
// In the engine the divider retires eight dividend bits a cycle; once all
// digits of a value are divided out and stored, each digit then needs a
// store read and an output step. The engine divides out every digit of a
// value before it shows the first one.
// A two-entry input queue lets up to two further words be taken while a
// conversion runs. When m_tready is low the current digit holds and the
// engine waits; the input side keeps accepting until the queue is full.
// ----------------------------------------------------------------------------
module integer_to_radix_digits
	import rdx_pkg::*;
#(
	parameter int VALUE_WIDTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [RADIX_W-1:0]    cfg_wdata,   // radix
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [VALUE_IN_W-1:0] s_tdata,     // [63:0] value
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,     // [6:0] digit_char, [7] zero
	output logic                  m_tlast      // last
);

	logic [RADIX_W-1:0]     radix_q;
	logic [RADIX_W-1:0]     radix_eff;
	logic                   q_valid;
	logic [VALUE_WIDTH-1:0] q_data;
	logic                   q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_we) begin
			radix_q <= cfg_wdata;
		end
	end

	// saturate the register into the usable range
	always_comb begin
		if (radix_q < RADIX_MIN) begin
			radix_eff = RADIX_MIN;
		end else if (radix_q > RADIX_MAX) begin
			radix_eff = RADIX_MAX;
		end else begin
			radix_eff = radix_q;
		end
	end

	rdx_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.q_valid (q_valid),
		.q_data  (q_data),
		.q_pop   (q_pop)
	);

	rdx_back #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.radix   (radix_eff),
		.q_valid (q_valid),
		.q_data  (q_data),
		.q_pop   (q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	a_run_end_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
		else $error("digit shown right after the end of a run");

	a_push_visible: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> q_valid)
		else $error("accepted word missing from the input queue");

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!m_tdata[7] && m_tdata[6:0] >= CHAR_ZERO && m_tdata[6:0] <= CHAR_TOP))
		else $error("digit symbol outside 0-9A-Z");

endmodule

// ----- design/rdx_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdx_front: input side of the radix converter
// Takes words from the input stream, keeps the significant bits and holds
// them in a two-entry queue until the conversion engine picks them up.
// ----------------------------------------------------------------------------
module rdx_front
	import rdx_pkg::*;
#(
	parameter int VALUE_WIDTH = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [VALUE_IN_W-1:0]  s_tdata,
	output logic                   q_valid,
	output logic [VALUE_WIDTH-1:0] q_data,
	input  logic                   q_pop
);

	logic [VALUE_WIDTH-1:0] slot_q [2];
	logic                   wr_ptr_q;
	logic                   rd_ptr_q;
	logic [1:0]             count_q;
	logic                   push;

	assign s_tready = (count_q != 2'd2);
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (count_q != 2'd0);
	assign q_data   = slot_q[rd_ptr_q];

	// drop the bits above VALUE_WIDTH on the way in
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= s_tdata[VALUE_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- design/rdx_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdx_back: conversion engine of the radix converter
// Divides the value by the radix DIV_BITS bits a cycle, stores each remainder
// as a digit, then reads the digits back most significant first as ASCII.
// ----------------------------------------------------------------------------
module rdx_back
	import rdx_pkg::*;
#(
	parameter int VALUE_WIDTH = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [RADIX_W-1:0]     radix,
	input  logic                   q_valid,
	input  logic [VALUE_WIDTH-1:0] q_data,
	output logic                   q_pop,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_DATA_W-1:0]  m_tdata,
	output logic                   m_tlast
);

	localparam int NCH  = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
	localparam int PADW = NCH * DIV_BITS;
	localparam int CHW  = (NCH > 1) ? $clog2(NCH) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_RD   = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]          state_q;
	logic [PADW-1:0]     quo_q;
	logic [RADIX_W-1:0]  rem_q;
	logic [CHW-1:0]      ch_q;
	logic [CNT_W-1:0]    n_q;
	logic [STORE_AW-1:0] k_q;
	logic [RADIX_W-1:0]  rd_q;
	logic [RADIX_W-1:0]  store [STORE_DEPTH];

	logic [RADIX_W-1:0]  r_next;
	logic [DIV_BITS-1:0] qbits;
	logic [RADIX_W:0]    t;
	logic [PADW-1:0]     quo_next;
	logic                last_chunk;
	logic                run_done;

	// restoring division over the top DIV_BITS bits of the shifting quotient
	always_comb begin
		r_next = rem_q;
		qbits  = '0;
		t      = '0;
		for (int i = 0; i < DIV_BITS; i++) begin
			t = {r_next, quo_q[PADW-1-i]};
			if (t >= {1'b0, radix}) begin
				r_next = RADIX_W'(t - {1'b0, radix});
				qbits[DIV_BITS-1-i] = 1'b1;
			end else begin
				r_next = t[RADIX_W-1:0];
			end
		end
	end

	assign quo_next   = (quo_q << DIV_BITS) | PADW'(qbits);
	assign last_chunk = (ch_q == CHW'(NCH - 1));
	assign run_done   = (quo_next == '0) || (n_q == CNT_W'(STORE_DEPTH - 1));

	assign q_pop    = (state_q == ST_IDLE) && q_valid;
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = {1'b0, digit_to_char(rd_q)};
	assign m_tlast  = (k_q == '0);

	always_ff @(posedge clk) begin
		if (state_q == ST_DIV && last_chunk) begin
			store[n_q[STORE_AW-1:0]] <= r_next;
		end
		if (state_q == ST_RD) begin
			rd_q <= store[k_q];
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				quo_q <= PADW'(q_data);
				rem_q <= '0;
			end
			ST_DIV: begin
				quo_q <= quo_next;
				rem_q <= last_chunk ? '0 : r_next;
			end
			default: begin
				quo_q <= quo_q;
				rem_q <= rem_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ch_q    <= '0;
			n_q     <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						ch_q    <= '0;
						n_q     <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (last_chunk) begin
						ch_q <= '0;
						n_q  <= n_q + CNT_W'(1);
						if (run_done) begin
							// most significant digit was just written
							k_q     <= n_q[STORE_AW-1:0];
							state_q <= ST_RD;
						end
					end else begin
						ch_q <= ch_q + CHW'(1);
					end
				end
				ST_RD: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (m_tready) begin
						if (k_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_q - STORE_AW'(1);
							state_q <= ST_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
